// ----- hw/rtl/mcwt_pkg.sv -----
// constants and types shared by the minimum covering window tracker
`default_nettype none

package mcwt_pkg;

  // default sizing
  localparam int unsigned DefSymbolSlots  = 128;
  localparam int unsigned DefRingDepth    = 1024;
  localparam int unsigned DefPositionBits = 20;

  // fixed field widths
  localparam int unsigned SymInBits = 12;
  localparam int unsigned KBits     = 7;
  localparam int unsigned LenBits   = 20;
  localparam int unsigned CountBits = 20;
  localparam int unsigned InBytes   = 2;
  localparam int unsigned OutBytes  = 3;

  localparam int unsigned KMax = 127;

  localparam logic [LenBits-1:0]   LenMax   = '1;
  localparam logic [CountBits-1:0] CountMax = '1;
  localparam logic [KBits-1:0]     KReset   = KBits'(1);

  typedef logic [LenBits-1:0]   len_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [KBits-1:0]     k_t;

endpackage

`default_nettype wire

// ----- hw/rtl/min_covering_window_tracker.sv -----
// top level of the minimum covering window tracker
`default_nettype none

// Takes one symbol per input item and returns one result item per symbol:
// whether every value 1..k has been seen in the current sequence, the
// shortest window length so far that holds all of them (all ones while there
// is none) and a sticky ring overflow flag. Per-symbol counts live in a
// SYMBOL_SLOTS-entry synchronous memory, with one valid bit per entry so a
// sequence start clears them at once; the window positions and symbols live
// in a RING_DEPTH-entry synchronous ring memory that is never cleared and is
// read only where the fill count says it holds data. Both memories have
// registered read data, and the front of the ring is mirrored in registers.
// Steps: a symbol outside 1..k goes through take and result, a counted
// symbol through take, count update and result. When a counted repeat
// matches the front of the ring, each check of the front adds a count read,
// together with the read of the entry behind the front, and then, on a pop,
// the count write back: one check per entry popped, plus a last check that
// finds the front still needed unless the ring runs empty. Each entry is
// popped at most once, so a counted symbol brings at most its own steps,
// one later pop of its entry and the last check of a pop run that it starts.
// Only one item is in flight; a finished result sits in the output register
// and the next item is taken while it waits, and a stalled output holds the
// block at its last cycle until the result is taken. symbols_needed may
// only be written while the block is idle. No clearing pass is needed after
// reset.
module min_covering_window_tracker
  import mcwt_pkg::*;
#(
  parameter int unsigned SYMBOL_SLOTS  = DefSymbolSlots,
  parameter int unsigned RING_DEPTH    = DefRingDepth,
  parameter int unsigned POSITION_BITS = DefPositionBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_wr_en_i,
  input  wire logic [KBits-1:0]      cfg_wr_data_i,   // symbols_needed
  // input items
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [8*InBytes-1:0]  s_axis_tdata,    // [11:0] symbol_value, rest zero
  input  wire logic                  s_axis_tuser,    // [0] sequence_start
  // result items
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [8*OutBytes-1:0]      m_axis_tdata     // [0] all_covered,
                                                      // [20:1] best_length,
                                                      // [21] ring_overflow, rest zero
);

  localparam int unsigned SB = (SYMBOL_SLOTS > 1) ? $clog2(SYMBOL_SLOTS) : 1;
  localparam int unsigned RB = $clog2(RING_DEPTH);
  localparam int unsigned FB = $clog2(RING_DEPTH + 1);
  localparam int unsigned PB = POSITION_BITS;
  localparam int unsigned EW = PB + SB;
  localparam int unsigned KCapInt = ((SYMBOL_SLOTS - 1) < KMax) ? (SYMBOL_SLOTS - 1) : KMax;
  localparam k_t KCap = KBits'(KCapInt);
  localparam logic [FB-1:0] FillFull = FB'(RING_DEPTH);
  localparam logic [RB-1:0] PtrLast  = RB'(RING_DEPTH - 1);
  localparam logic [PB-1:0] PosMax   = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COUNT,
    S_POP_RD,
    S_POP_UPD,
    S_DONE
  } state_e;

  // new best length after looking at the window from fpos up to pos
  function automatic len_t window_best(input logic [PB-1:0] pos,
                                       input logic [PB-1:0] fpos,
                                       input len_t best);
    logic [32:0] diff;
    len_t        len;
    diff = 33'(pos) - 33'(fpos) + 33'd1;
    len  = (diff > 33'(LenMax)) ? LenMax : diff[LenBits-1:0];
    if (fpos > pos) begin
      window_best = best;
    end else begin
      window_best = (len < best) ? len : best;
    end
  endfunction

  // storage
  count_t                  cnt_mem [SYMBOL_SLOTS];
  logic [EW-1:0]           ring_mem [RING_DEPTH];
  count_t                  cnt_rdata_q;
  logic [EW-1:0]           ring_rdata_q;

  // memory port controls
  logic                    cnt_we;
  logic [SB-1:0]           cnt_waddr;
  count_t                  cnt_wdata;
  logic [SB-1:0]           cnt_raddr;
  logic                    ring_we;
  logic [EW-1:0]           ring_wdata;
  logic [RB-1:0]           ring_raddr;

  // control state
  state_e                  state_q, state_d;
  k_t                      cfg_q;
  logic [SB-1:0]           sym_q, sym_d;
  logic [PB-1:0]           pos_q, pos_d;
  logic [RB-1:0]           head_q, head_d;
  logic [RB-1:0]           tail_q, tail_d;
  logic [FB-1:0]           fill_q, fill_d;
  k_t                      dist_q, dist_d;
  len_t                    best_q, best_d;
  logic                    ovf_q, ovf_d;
  logic [PB-1:0]           front_pos_q, front_pos_d;
  logic [SB-1:0]           front_sym_q, front_sym_d;
  logic [SYMBOL_SLOTS-1:0] cnt_vld_q, cnt_vld_d;
  logic                    cnt_hit_q, cnt_hit_d;
  logic                    out_vld_q, out_vld_d;
  logic [8*OutBytes-1:0]   out_data_q, out_data_d;

  // helpers
  k_t                      k_raw, k_eff;
  logic                    in_accept;
  logic [SymInBits-1:0]    sym_in;
  logic                    in_range;
  logic [PB-1:0]           pos_base;
  logic [RB-1:0]           head_next, tail_next;
  count_t                  cnt_cur, cnt_new;
  k_t                      dist_new;
  logic [PB-1:0]           fpos;
  logic [SB-1:0]           fsym;

  // zero k counts as one, large k is capped by the table size
  assign k_raw = (cfg_q == '0) ? KBits'(1) : cfg_q;
  assign k_eff = (k_raw > KCap) ? KCap : k_raw;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign sym_in        = s_axis_tdata[SymInBits-1:0];
  assign in_range      = (sym_in != '0) && (sym_in <= SymInBits'(k_eff));

  assign head_next = (head_q == PtrLast) ? '0 : head_q + 1'b1;
  assign tail_next = (tail_q == PtrLast) ? '0 : tail_q + 1'b1;

  // a count entry not written in this sequence reads as zero
  assign cnt_cur = cnt_hit_q ? cnt_rdata_q : '0;
  assign cnt_new = (cnt_cur == CountMax) ? cnt_cur : cnt_cur + 1'b1;
  assign dist_new = (dist_q == k_t'(KMax)) ? dist_q : dist_q + 1'b1;

  // front of the ring once this item's entry is pushed
  assign fpos = (fill_q == '0) ? pos_q : front_pos_q;
  assign fsym = (fill_q == '0) ? sym_q : front_sym_q;

  assign pos_base = (in_accept && s_axis_tuser) ? '0 : pos_q;

  always_comb begin
    state_d     = state_q;
    sym_d       = sym_q;
    pos_d       = pos_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    dist_d      = dist_q;
    best_d      = best_q;
    ovf_d       = ovf_q;
    front_pos_d = front_pos_q;
    front_sym_d = front_sym_q;
    cnt_vld_d   = cnt_vld_q;
    cnt_hit_d   = cnt_hit_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_data_d  = out_data_q;

    cnt_we      = 1'b0;
    cnt_waddr   = sym_q;
    cnt_wdata   = cnt_new;
    cnt_raddr   = sym_in[SB-1:0];
    ring_we     = 1'b0;
    ring_wdata  = {pos_q, sym_q};
    ring_raddr  = head_next;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          if (s_axis_tuser) begin
            // new sequence: everything but k starts over
            head_d    = '0;
            tail_d    = '0;
            fill_d    = '0;
            dist_d    = '0;
            best_d    = LenMax;
            ovf_d     = 1'b0;
            cnt_vld_d = '0;
          end
          pos_d     = (pos_base == PosMax) ? pos_base : pos_base + 1'b1;
          sym_d     = sym_in[SB-1:0];
          cnt_hit_d = !s_axis_tuser && cnt_vld_q[sym_in[SB-1:0]];
          state_d   = in_range ? S_COUNT : S_DONE;
        end
      end

      S_COUNT: begin
        cnt_we           = 1'b1;
        cnt_vld_d[sym_q] = 1'b1;
        if (fill_q != FillFull) begin
          ring_we = 1'b1;
          tail_d  = tail_next;
          fill_d  = fill_q + 1'b1;
          if (fill_q == '0) begin
            front_pos_d = pos_q;
            front_sym_d = sym_q;
          end
        end else begin
          ovf_d = 1'b1;
        end
        state_d = S_DONE;
        if (cnt_new == count_t'(1)) begin
          dist_d = dist_new;
          if (dist_new == k_eff) begin
            best_d = window_best(pos_q, fpos, best_q);
          end
        end else if (fsym == sym_q) begin
          state_d = S_POP_RD;
        end
      end

      S_POP_RD: begin
        // count of the front symbol, and the entry behind the front
        cnt_raddr = front_sym_q;
        cnt_hit_d = cnt_vld_q[front_sym_q];
        state_d   = S_POP_UPD;
      end

      S_POP_UPD: begin
        if (cnt_cur <= count_t'(1)) begin
          if (dist_q == k_eff) begin
            best_d = window_best(pos_q, front_pos_q, best_q);
          end
          state_d = S_DONE;
        end else begin
          cnt_we      = 1'b1;
          cnt_waddr   = front_sym_q;
          cnt_wdata   = cnt_cur - 1'b1;
          head_d      = head_next;
          fill_d      = fill_q - 1'b1;
          front_pos_d = ring_rdata_q[EW-1:SB];
          front_sym_d = ring_rdata_q[SB-1:0];
          // ring emptied: no window to look at
          state_d     = (fill_q == FB'(1)) ? S_DONE : S_POP_RD;
        end
      end

      S_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_data_d = {{(8*OutBytes - LenBits - 2){1'b0}}, ovf_q, best_q,
                        (dist_q == k_eff)};
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= KReset;
      sym_q       <= '0;
      pos_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      dist_q      <= '0;
      best_q      <= LenMax;
      ovf_q       <= 1'b0;
      front_pos_q <= '0;
      front_sym_q <= '0;
      cnt_vld_q   <= '0;
      cnt_hit_q   <= 1'b0;
      out_vld_q   <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      if (cfg_wr_en_i) begin
        cfg_q <= cfg_wr_data_i;
      end
      sym_q       <= sym_d;
      pos_q       <= pos_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fill_q      <= fill_d;
      dist_q      <= dist_d;
      best_q      <= best_d;
      ovf_q       <= ovf_d;
      front_pos_q <= front_pos_d;
      front_sym_q <= front_sym_d;
      cnt_vld_q   <= cnt_vld_d;
      cnt_hit_q   <= cnt_hit_d;
      out_vld_q   <= out_vld_d;
      out_data_q  <= out_data_d;
    end
  end

  // symbol count memory
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata_q <= cnt_mem[cnt_raddr];
  end

  // window ring memory, written at the tail, read behind the head
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[tail_q] <= ring_wdata;
    end
    ring_rdata_q <= ring_mem[ring_raddr];
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // ring never holds more than its depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillFull)
    else $error("ring fill above depth");

  // a pop is only attempted on a non-empty ring
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP_RD || state_q == S_POP_UPD) |-> fill_q != '0)
    else $error("pop on empty ring");

  // best length only shrinks within a sequence
  a_best_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> best_q <= $past(best_q))
    else $error("best length grew without a new sequence");

endmodule

`default_nettype wire
